// ===== rtl/reply_frame_crc_checker_unit_assert.svh =====
// Assertion macros shared by the reply frame CRC checker RTL.
`ifndef REPLY_FRAME_CRC_CHECKER_UNIT_ASSERT_SVH
`define REPLY_FRAME_CRC_CHECKER_UNIT_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define RFCC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Condition in one cycle forces a consequence in the next.
`define RFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfcc_pkg.sv =====
// Types, codes and CRC helper for the reply frame CRC checker.
`default_nettype none

package rfcc_pkg;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [7:0]  AddrReset  = 8'd128;

  localparam logic        ReqStart   = 1'b0;
  localparam logic        ReqByte    = 1'b1;

  localparam logic [1:0]  FmtU16     = 2'd0;
  localparam logic [1:0]  FmtU32     = 2'd1;
  localparam logic [1:0]  FmtSigned  = 2'd2;

  localparam logic [1:0]  StatusOk      = 2'd0;
  localparam logic [1:0]  StatusCrcBad  = 2'd1;
  localparam logic [1:0]  StatusNoFrame = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] command_code;
    logic [1:0] reply_format;
    logic [7:0] rx_byte;
  } rfcc_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } rfcc_res_t;

  // One byte through CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] rfcc_crc_fold(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the reset device address alone.
  localparam logic [15:0] AddrCrcReset = rfcc_crc_fold(16'h0000, AddrReset);

endpackage

`default_nettype wire

// ===== rtl/rfcc_frame.sv =====
// Frame state and per-byte decode: CRC, payload assembly and result.
`default_nettype none

module rfcc_frame
  import rfcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire rfcc_req_t   req_i,
  input  wire logic [15:0] addr_crc_i,
  output      logic        res_valid_o,
  output      rfcc_res_t   res_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] rcv_q, rcv_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  pos_q, pos_d;
  logic [1:0]  fmt_q, fmt_d;
  logic        open_q, open_d;

  logic [2:0]  plen;
  logic        has_dir;
  logic [2:0]  crc_at;
  logic [15:0] crc_fold;

  assign plen     = (fmt_q == FmtU16) ? 3'd2 : 3'd4;
  assign has_dir  = fmt_q[1];
  assign crc_at   = plen + {2'b00, has_dir};
  assign crc_fold = rfcc_crc_fold(crc_q, req_i.rx_byte);

  always_comb begin
    crc_d       = crc_q;
    rcv_d       = rcv_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    fmt_d       = fmt_q;
    open_d      = open_q;
    res_valid_o = 1'b0;
    res_o.value  = '0;
    res_o.status = StatusNoFrame;

    if (req_i.req_type == ReqStart) begin
      crc_d  = rfcc_crc_fold(addr_crc_i, req_i.command_code);
      rcv_d  = '0;
      acc_d  = '0;
      pos_d  = '0;
      fmt_d  = req_i.reply_format;
      open_d = 1'b1;
    end else if (!open_q) begin
      res_valid_o = 1'b1;
    end else begin
      pos_d = pos_q + 3'd1;
      if (pos_q < plen) begin
        acc_d = {acc_q[23:0], req_i.rx_byte};
        crc_d = crc_fold;
      end else if (has_dir && pos_q == plen) begin
        crc_d = crc_fold;
        // nonzero direction byte: negate modulo 2^32
        if (req_i.rx_byte != 8'h00) begin
          acc_d = 32'h0 - acc_q;
        end
      end else if (pos_q == crc_at) begin
        rcv_d = {req_i.rx_byte, 8'h00};
      end else begin
        rcv_d        = rcv_q | {8'h00, req_i.rx_byte};
        res_valid_o  = 1'b1;
        res_o.value  = acc_q;
        res_o.status = ({rcv_q[15:8], req_i.rx_byte} == crc_q) ? StatusOk : StatusCrcBad;
        open_d       = 1'b0;
        pos_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      rcv_q  <= '0;
      acc_q  <= '0;
      pos_q  <= '0;
      fmt_q  <= FmtU16;
      open_q <= 1'b0;
    end else if (adv_i) begin
      crc_q  <= crc_d;
      rcv_q  <= rcv_d;
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      fmt_q  <= fmt_d;
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/reply_frame_crc_checker_unit.sv =====
// Top level of the reply frame CRC checker: request, decode and result registers.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_req_i   (rfcc_req_t)
//   out      output     out_valid_o / out_stall_i out_res_o (rfcc_res_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (device address)
//
// A request is registered, decoded combinationally and its result lands in the
// output register; one request per cycle while in_stall_o is low.
// Reset clears the frame state and loads device address 128; cfg is always ready.
// in_stall_o rises only while a result-bearing request waits on a full, stalled
// output register.
`default_nettype none
`include "reply_frame_crc_checker_unit_assert.svh"

module reply_frame_crc_checker_unit
  import rfcc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire rfcc_req_t  in_req_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      rfcc_res_t  out_res_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic [15:0] addr_crc_q;
  logic        s1_valid_q;
  rfcc_req_t   s1_req_q;
  logic        out_valid_q;
  rfcc_res_t   out_res_q;

  logic        res_valid;
  rfcc_res_t   res;
  logic        out_free;
  logic        s1_adv;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // Hold the CRC of the address byte so a start folds only the command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_crc_q <= AddrCrcReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      addr_crc_q <= rfcc_crc_fold(16'h0000, cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q <= in_req_i;
    end
  end

  rfcc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .req_i       (s1_req_q),
    .addr_crc_i  (addr_crc_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_adv && res_valid) begin
      out_res_q <= res;
    end
  end

  `RFCC_ASSERT_ALWAYS(a_stall_needs_request, !in_stall_o || s1_valid_q,
    "stall raised with no request held")
  `RFCC_ASSERT_ALWAYS(a_stall_on_blocked_result,
    !(s1_valid_q && res_valid && out_valid_q && out_stall_i) || in_stall_o,
    "result request advanced into a full stalled output")
  `RFCC_ASSERT_ALWAYS(a_no_frame_value_zero,
    !(out_valid_q && out_res_q.status == StatusNoFrame) || out_res_q.value == 32'h0,
    "no-frame result carries a nonzero value")
  `RFCC_ASSERT_NEXT(a_drain_clears_output,
    out_valid_q && !out_stall_i && !(s1_adv && res_valid), !out_valid_q,
    "taken result shown again")

endmodule

`default_nettype wire

// ===== dv/reply_frame_crc_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the reply frame CRC checker: directed frames, then predicted random traffic.
module reply_frame_crc_checker_unit_tb;
  import rfcc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;
  localparam int RandomItems = 150;
  localparam int HoldCycles  = 80;

  // Format code 3 decodes like the signed format.
  localparam logic [1:0] FmtSignedAlt = 2'd3;

  localparam rfcc_res_t NoRes      = '{32'h0, StatusOk};
  localparam rfcc_res_t NoFrameRes = '{32'h0, StatusNoFrame};

  typedef enum logic [1:0] {RowPlain, RowCrcHi, RowCrcLo} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    rfcc_req_t req;
    logic      typed;
    rfcc_res_t res;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  rfcc_req_t   in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rfcc_res_t   out_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i  = 8'h00;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  // Predicted frame state.
  logic [7:0]  dev_addr;
  logic [15:0] frame_crc;
  logic [15:0] frame_rx_crc;
  logic [31:0] frame_value;
  logic [2:0]  frame_pos;
  logic [1:0]  frame_fmt;
  logic        frame_open;

  rfcc_res_t frame_results_q[$];

  stim_row_t directed_rows [24] = '{
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'hFF}, 1'b1, NoFrameRes},
    '{RowPlain, '{ReqStart, 8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowCrcHi, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowCrcLo, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    // frame just closed, so this byte finds no open request
    '{RowPlain, '{ReqByte,  8'hFF, FmtSigned,    8'h00}, 1'b1, NoFrameRes},
    '{RowPlain, '{ReqStart, 8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'hFF, FmtU32,       8'hFF}, 1'b0, NoRes},
    // abandoned after one byte by the next start
    '{RowPlain, '{ReqStart, 8'hA5, FmtSignedAlt, 8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h80}, 1'b0, NoRes},
    '{RowPlain, '{ReqStart, 8'h5A, FmtSigned,    8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'h01}, 1'b0, NoRes},
    '{RowPlain, '{ReqByte,  8'h00, FmtU16,       8'hFF}, 1'b0, NoRes},
    '{RowCrcHi, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes},
    '{RowCrcLo, '{ReqByte,  8'h00, FmtU16,       8'h00}, 1'b0, NoRes}
  };

  reply_frame_crc_checker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_shift(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  task automatic track_frame(input rfcc_req_t r, output logic has_res, output rfcc_res_t res);
    logic [2:0] plen;
    logic [2:0] crc_at;
    logic       has_dir;
    has_res = 1'b0;
    res     = NoRes;
    if (r.req_type == ReqStart) begin
      frame_crc    = crc16_shift(crc16_shift(16'h0000, dev_addr), r.command_code);
      frame_rx_crc = 16'h0000;
      frame_value  = 32'h0;
      frame_pos    = 3'd0;
      frame_fmt    = r.reply_format;
      frame_open   = 1'b1;
    end else if (!frame_open) begin
      has_res = 1'b1;
      res     = NoFrameRes;
    end else begin
      plen    = (frame_fmt == FmtU16) ? 3'd2 : 3'd4;
      has_dir = (frame_fmt >= FmtSigned);
      crc_at  = plen + {2'b00, has_dir};
      if (frame_pos < plen) begin
        frame_value = {frame_value[23:0], r.rx_byte};
        frame_crc   = crc16_shift(frame_crc, r.rx_byte);
        frame_pos++;
      end else if (has_dir && frame_pos == plen) begin
        frame_crc = crc16_shift(frame_crc, r.rx_byte);
        if (r.rx_byte != 8'h00) frame_value = -frame_value;
        frame_pos++;
      end else if (frame_pos == crc_at) begin
        frame_rx_crc = {r.rx_byte, 8'h00};
        frame_pos++;
      end else begin
        frame_rx_crc = frame_rx_crc | {8'h00, r.rx_byte};
        has_res      = 1'b1;
        res.value    = frame_value;
        res.status   = (frame_rx_crc == frame_crc) ? StatusOk : StatusCrcBad;
        frame_open   = 1'b0;
        frame_pos    = 3'd0;
      end
    end
  endtask

  // Entered and left just after a falling edge.
  task automatic send_req(input rfcc_req_t r, input logic typed, input rfcc_res_t typed_res);
    logic      has_res;
    rfcc_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    track_frame(r, has_res, res);
    if (typed) frame_results_q = {frame_results_q, typed_res};
    else if (has_res) frame_results_q = {frame_results_q, res};
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    rfcc_req_t r;
    r.req_type     = ReqByte;
    r.command_code = 8'($urandom);
    r.reply_format = 2'($urandom);
    r.rx_byte      = b;
    send_req(r, 1'b0, NoRes);
  endtask

  task automatic send_start(input logic [1:0] fmt);
    rfcc_req_t r;
    r.req_type     = ReqStart;
    r.command_code = 8'($urandom);
    r.reply_format = fmt;
    r.rx_byte      = 8'($urandom);
    send_req(r, 1'b0, NoRes);
  endtask

  // Mostly whole frames with random content; the rest truncated frames and stray bytes.
  task automatic run_random(input int n);
    int         sent;
    int         pick;
    int         plen;
    int         k;
    logic [1:0] fmt;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        fmt  = 2'($urandom);
        plen = (fmt == FmtU16) ? 2 : 4;
        send_start(fmt);
        repeat (plen) send_byte(8'($urandom));
        if (fmt >= FmtSigned) begin
          b = 8'($urandom);
          if ($urandom_range(1) == 0) b = 8'h00;
          send_byte(b);
          sent++;
        end
        hi = frame_crc[15:8];
        lo = frame_crc[7:0];
        k  = $urandom_range(7);
        case ($urandom_range(3))
          0: hi[k] = ~hi[k];
          1: lo[k] = ~lo[k];
          default: ;
        endcase
        send_byte(hi);
        send_byte(lo);
        sent += plen + 3;
      end else if (pick < 88) begin
        send_start(2'($urandom));
        k = $urandom_range(3);
        repeat (k) send_byte(8'($urandom));
        sent += k + 1;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) send_byte(8'($urandom));
        sent += k;
      end
    end
  endtask

  // Drop valid, wait out every expected result, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] d);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    dev_addr = d;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    rfcc_res_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        $error("unexpected result: value %h status %0d", out_res_o.value, out_res_o.status);
        fail_count++;
      end else begin
        due = frame_results_q[0];
        frame_results_q.delete(0);
        if (out_res_o.value !== due.value) begin
          $error("value: expected %h, got %h", due.value, out_res_o.value);
          fail_count++;
        end
        if (out_res_o.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_res_o.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("reply_frame_crc_checker_unit test failed");
    $finish;
  end

  initial begin
    rfcc_req_t r;
    dev_addr     = AddrReset;
    frame_crc    = 16'h0000;
    frame_rx_crc = 16'h0000;
    frame_value  = 32'h0;
    frame_pos    = 3'd0;
    frame_fmt    = FmtU16;
    frame_open   = 1'b0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows run on the reset address.
    set_idling(21, 69);
    foreach (directed_rows[i]) begin
      r = directed_rows[i].req;
      if (directed_rows[i].kind == RowCrcHi) r.rx_byte = frame_crc[15:8];
      else if (directed_rows[i].kind == RowCrcLo) r.rx_byte = frame_crc[7:0];
      send_req(r, directed_rows[i].typed, directed_rows[i].res);
    end
    wait_idle();

    write_address(8'h00);
    run_random(RandomItems);
    wait_idle();

    set_idling(69, 21);
    write_address(8'hFF);
    run_random(RandomItems);
    wait_idle();

    set_idling(0, 0);
    write_address(8'($urandom));
    // Hold the output off so that the block backs up into its input.
    @(posedge clk_i);
    hold_req = HoldCycles;
    @(negedge clk_i);
    run_random(RandomItems);
    wait_idle();

    if (fail_count == 0) begin
      $display("reply_frame_crc_checker_unit test passed");
    end else begin
      $display("reply_frame_crc_checker_unit test failed");
    end
    $finish;
  end

endmodule
